>>> rtl/pps_pkg.sv
// Shared types, codes and constants of the point-in-polygon side test.
`timescale 1ns / 1ps
package pps_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_W          = 32;
    localparam int DIFF_W           = COORD_W + 2;
    localparam int PROD_W           = 2 * DIFF_W;
    localparam int MIN_VERTS        = 3;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_REF    = 2'd2;
    localparam logic [1:0] ACT_TEST   = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_FEW  = 2'd2;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } cmd_t;

endpackage

>>> rtl/pps_if.sv
// Valid/ready channel interfaces for item and result beats.
`timescale 1ns / 1ps
interface pps_in_if import pps_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;

    modport source (output valid, output action, output px, output py, input ready);
    modport sink   (input valid, input action, input px, input py, output ready);
endinterface

interface pps_out_if ();
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       inside_res;
    logic       odd_crossings;

    modport source (output valid, output status, output inside_res, output odd_crossings,
                    input ready);
    modport sink   (input valid, input status, input inside_res, input odd_crossings,
                    output ready);
endinterface

>>> rtl/pps_front.sv
// Front end: accepts item beats, passes the action through and queues commands.
`timescale 1ns / 1ps
module pps_front import pps_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    pps_in_if.sink   item,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_ready
);

    cmd_t       queue_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    cmd_t       entry;

    assign item.ready = (fill_reg != 2'd2);
    assign push       = item.valid && item.ready;
    assign cmd_valid  = (fill_reg != 2'd0);
    assign pop        = cmd_valid && cmd_ready;
    assign cmd        = queue_reg[rd_ptr_reg];

    always_comb
    begin
        entry.action = item.action;
        entry.px     = item.px;
        entry.py     = item.py;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

>>> rtl/pps_back.sv
// Back end: vertex store, pipelined edge walker and result register.
`timescale 1ns / 1ps
module pps_back import pps_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_ready,
    pps_out_if.source result
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];

    logic                      state_reg;
    logic [CW-1:0]             count_reg;
    logic                      ref_odd_reg;
    logic                      is_ref_reg;
    logic signed [COORD_W-1:0] pt_x_reg;
    logic signed [COORD_W-1:0] pt_y_reg;

    logic                      iss_reg;
    logic [AW-1:0]             rd_idx_reg;
    logic                      rd_vld_reg;
    logic                      rd_first_reg;
    logic                      rd_last_reg;
    logic signed [COORD_W-1:0] rd_x_reg;
    logic signed [COORD_W-1:0] rd_y_reg;
    logic signed [COORD_W-1:0] v0_x_reg;
    logic signed [COORD_W-1:0] v0_y_reg;
    logic signed [COORD_W-1:0] prev_x_reg;
    logic signed [COORD_W-1:0] prev_y_reg;
    logic                      close_reg;

    logic                      e_vld_reg;
    logic                      e_last_reg;
    logic                      e_in_reg;
    logic signed [COORD_W-1:0] e_xa_reg;
    logic signed [COORD_W-1:0] e_ya_reg;
    logic signed [COORD_W-1:0] e_xb_reg;
    logic signed [COORD_W-1:0] e_yb_reg;

    logic                      d_vld_reg;
    logic                      d_last_reg;
    logic                      d_in_reg;
    logic signed [DIFF_W-1:0]  d_a_reg;
    logic signed [DIFF_W-1:0]  d_b_reg;
    logic signed [DIFF_W-1:0]  d_c_reg;
    logic signed [DIFF_W-1:0]  d_d_reg;

    logic                      m_vld_reg;
    logic                      m_last_reg;
    logic                      m_in_reg;
    logic signed [PROD_W-1:0]  m_pa_reg;
    logic signed [PROD_W-1:0]  m_pc_reg;

    logic                      parity_reg;
    logic                      parity_next;

    logic                      out_vld_reg;
    logic                      out_vld_next;
    logic [1:0]                status_reg;
    logic                      inside_reg;
    logic                      odd_reg;

    logic                      pop;
    logic                      walk_start;
    logic                      out_free;
    logic                      mem_we;
    logic                      iss_last;
    logic                      finish;
    logic                      edge_vld;
    logic signed [COORD_W-1:0] ea_x;
    logic signed [COORD_W-1:0] ea_y;
    logic signed [COORD_W-1:0] eb_x;
    logic signed [COORD_W-1:0] eb_y;
    logic                      edge_swap;
    logic                      edge_in;

    assign out_free   = !out_vld_reg || result.ready;
    assign cmd_ready  = (state_reg == ST_IDLE) && out_free;
    assign pop        = cmd_valid && cmd_ready;
    assign walk_start = pop && ((cmd.action == ACT_REF) || (cmd.action == ACT_TEST))
                        && (count_reg >= CW'(MIN_VERTS));
    assign mem_we     = pop && (cmd.action == ACT_APPEND)
                        && (count_reg < CW'(MAX_VERTICES));
    assign iss_last   = (CW'(rd_idx_reg) == (count_reg - CW'(1)));

    assign edge_vld  = (rd_vld_reg && !rd_first_reg) || close_reg;
    assign ea_x      = prev_x_reg;
    assign ea_y      = prev_y_reg;
    assign eb_x      = close_reg ? v0_x_reg : rd_x_reg;
    assign eb_y      = close_reg ? v0_y_reg : rd_y_reg;
    assign edge_swap = ea_x > eb_x;
    assign edge_in   = ((ea_x < pt_x_reg) && (pt_x_reg < eb_x))
                       || ((eb_x < pt_x_reg) && (pt_x_reg < ea_x));

    assign parity_next  = parity_reg ^ (m_vld_reg && m_in_reg && (m_pa_reg > m_pc_reg));
    assign finish       = m_vld_reg && m_last_reg;
    assign out_vld_next = (pop && !walk_start) || finish || (out_vld_reg && !result.ready);

    assign result.valid         = out_vld_reg;
    assign result.status        = status_reg;
    assign result.inside_res    = inside_reg;
    assign result.odd_crossings = odd_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_x[count_reg[AW-1:0]] <= cmd.px;
            mem_y[count_reg[AW-1:0]] <= cmd.py;
        end
        rd_x_reg <= mem_x[rd_idx_reg];
        rd_y_reg <= mem_y[rd_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pt_x_reg   <= cmd.px;
            pt_y_reg   <= cmd.py;
            is_ref_reg <= (cmd.action == ACT_REF);
        end
        if (rd_vld_reg)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
            if (rd_first_reg)
            begin
                v0_x_reg <= rd_x_reg;
                v0_y_reg <= rd_y_reg;
            end
        end
        e_in_reg <= edge_in;
        e_xa_reg <= edge_swap ? eb_x : ea_x;
        e_ya_reg <= edge_swap ? eb_y : ea_y;
        e_xb_reg <= edge_swap ? ea_x : eb_x;
        e_yb_reg <= edge_swap ? ea_y : eb_y;
        d_in_reg <= e_in_reg;
        d_a_reg  <= {{2{pt_y_reg[COORD_W-1]}}, pt_y_reg}
                    - {{2{e_ya_reg[COORD_W-1]}}, e_ya_reg};
        d_b_reg  <= {{2{e_xb_reg[COORD_W-1]}}, e_xb_reg}
                    - {{2{e_xa_reg[COORD_W-1]}}, e_xa_reg};
        d_c_reg  <= {{2{e_yb_reg[COORD_W-1]}}, e_yb_reg}
                    - {{2{e_ya_reg[COORD_W-1]}}, e_ya_reg};
        d_d_reg  <= {{2{pt_x_reg[COORD_W-1]}}, pt_x_reg}
                    - {{2{e_xa_reg[COORD_W-1]}}, e_xa_reg};
        m_in_reg <= d_in_reg;
        m_pa_reg <= d_a_reg * d_b_reg;
        m_pc_reg <= d_c_reg * d_d_reg;
        if (pop)
        begin
            inside_reg <= 1'b0;
            odd_reg    <= 1'b0;
            case (cmd.action)
                ACT_CLEAR:
                begin
                    status_reg <= STAT_OK;
                end
                ACT_APPEND:
                begin
                    if (count_reg >= CW'(MAX_VERTICES))
                    begin
                        status_reg <= STAT_FULL;
                    end
                    else
                    begin
                        status_reg <= STAT_OK;
                    end
                end
                default:
                begin
                    if (count_reg < CW'(MIN_VERTS))
                    begin
                        status_reg <= STAT_FEW;
                    end
                    else
                    begin
                        status_reg <= STAT_OK;
                    end
                end
            endcase
        end
        else if (finish)
        begin
            status_reg <= STAT_OK;
            odd_reg    <= parity_next;
            inside_reg <= is_ref_reg ? 1'b1 : (parity_next == ref_odd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            ref_odd_reg  <= 1'b0;
            iss_reg      <= 1'b0;
            rd_idx_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            close_reg    <= 1'b0;
            e_vld_reg    <= 1'b0;
            e_last_reg   <= 1'b0;
            d_vld_reg    <= 1'b0;
            d_last_reg   <= 1'b0;
            m_vld_reg    <= 1'b0;
            m_last_reg   <= 1'b0;
            parity_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= iss_reg;
            rd_first_reg <= iss_reg && (rd_idx_reg == '0);
            rd_last_reg  <= iss_reg && iss_last;
            close_reg    <= rd_vld_reg && rd_last_reg;
            e_vld_reg    <= edge_vld;
            e_last_reg   <= close_reg;
            d_vld_reg    <= e_vld_reg;
            d_last_reg   <= e_last_reg;
            m_vld_reg    <= d_vld_reg;
            m_last_reg   <= d_last_reg;
            parity_reg   <= pop ? 1'b0 : parity_next;
            out_vld_reg  <= out_vld_next;

            if (iss_reg)
            begin
                rd_idx_reg <= rd_idx_reg + AW'(1);
                if (iss_last)
                begin
                    iss_reg <= 1'b0;
                end
            end

            if (pop)
            begin
                case (cmd.action)
                    ACT_CLEAR:
                    begin
                        count_reg <= '0;
                    end
                    ACT_APPEND:
                    begin
                        if (mem_we)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                    default:
                    begin
                        if (walk_start)
                        begin
                            state_reg  <= ST_WALK;
                            iss_reg    <= 1'b1;
                            rd_idx_reg <= '0;
                        end
                    end
                endcase
            end
            else if (finish)
            begin
                state_reg <= ST_IDLE;
                if (is_ref_reg)
                begin
                    ref_odd_reg <= parity_next;
                end
            end
        end
    end

endmodule

>>> rtl/point_in_polygon_side_test.sv
// Clear, append and too-few-vertex beats go through the command queue and result register,
// one per cycle while results are taken. A reference or test point with N stored vertices
// is walked one edge per cycle over the single read port of the vertex store into a
// four-stage compare pipeline. Items are worked one at a time; a
// two-entry command queue and the result register let the input accept beats while a result
// waits. Reset empties the polygon and sets the reference parity to even, not the store.
`timescale 1ns / 1ps
module point_in_polygon_side_test import pps_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pps_in_if.sink    item,
    pps_out_if.source result
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    pps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    pps_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .result    (result)
    );

endmodule
